FILE: design/uvt_pkg.sv
// ----------------------------------------------------------------------------
// uvt_pkg
// Types and codes that the value table modules share.
// ----------------------------------------------------------------------------
package uvt_pkg;

  localparam int unsigned VALUE_W    = 7;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned FILL_W     = 5;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FILL_W-1:0]  fill_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t status;
    pos_t    position;
    fill_t   fill_count;
  } rsp_t;

endpackage

FILE: design/uvt_if.sv
// ----------------------------------------------------------------------------
// uvt_req_if / uvt_rsp_if
// Valid/ready channels for requests and results of the value table.
// ----------------------------------------------------------------------------
interface uvt_req_if;
  logic           valid;
  logic           ready;
  uvt_pkg::mode_t mode;
  uvt_pkg::value_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface uvt_rsp_if;
  logic             valid;
  logic             ready;
  uvt_pkg::status_t status;
  uvt_pkg::pos_t    position;
  uvt_pkg::fill_t   fill_count;

  modport source (output valid, output status, output position, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input position, input fill_count,
                  output ready);
endinterface

FILE: design/uvt_ram.sv
// ----------------------------------------------------------------------------
// uvt_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module uvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/uvt_engine.sv
// ----------------------------------------------------------------------------
// uvt_engine
// Request sequencer: appends, scans the value memory one entry per cycle,
// and fills a removed slot with the last stored entry.
// ----------------------------------------------------------------------------
module uvt_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  uvt_req_if.sink       in_chan,
  output logic          res_valid,
  input  logic          res_ready,
  output uvt_pkg::rsp_t res_data
);
  import uvt_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  value_t             value_r, value_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  rsp_t               res_r, res_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  value_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  value_t             ram_rdata;

  logic               full;
  logic               empty;
  logic               hit;
  logic               at_last;
  logic [IDX_W-1:0]   last_idx;
  logic [CNT_W-1:0]   count_dec;
  logic [CNT_W-1:0]   count_inc;

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - 1'b1;
  assign count_inc = count_r + 1'b1;
  assign last_idx  = IDX_W'(count_dec);
  assign hit       = (ram_rdata == value_r);
  assign at_last   = (idx_r == last_idx);

  uvt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if ((in_chan.mode inside {MODE_REMOVE, MODE_FIND}) && !empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (mode_r == MODE_FIND || at_last) ? S_DONE : S_FETCH;
        end else if (at_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FETCH: state_nxt = S_MOVE;
      S_MOVE:  state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == S_IDLE);
    res_valid     = (state_r == S_DONE);
    res_data      = res_r;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(count_r);
    ram_wdata     = in_chan.value;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        ram_we = in_chan.valid && (in_chan.mode == MODE_ADD) && !full;
        ram_re = in_chan.valid && (in_chan.mode inside {MODE_REMOVE, MODE_FIND});
      end
      S_SCAN: begin
        ram_re    = !hit && !at_last;
        ram_raddr = idx_r + 1'b1;
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx;
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    value_nxt = value_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          mode_nxt  = in_chan.mode;
          value_nxt = in_chan.value;
          idx_nxt   = '0;
          res_nxt   = '{status: ST_OK, position: '0, fill_count: FILL_W'(count_r)};
          case (in_chan.mode)
            MODE_ADD: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                count_nxt            = count_inc;
                res_nxt.position     = POS_W'(count_r);
                res_nxt.fill_count   = FILL_W'(count_inc);
              end
            end
            MODE_REMOVE, MODE_FIND: begin
              if (empty) begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_nxt = '{status: ST_OK, position: POS_W'(idx_r), fill_count: FILL_W'(count_r)};
          if (mode_r == MODE_REMOVE && at_last) begin
            count_nxt          = count_dec;
            res_nxt.fill_count = FILL_W'(count_dec);
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (at_last) begin
            res_nxt = '{status: ST_NOT_FOUND, position: '0, fill_count: FILL_W'(count_r)};
          end
        end
      end
      S_MOVE: begin
        count_nxt = count_dec;
        res_nxt   = '{status: ST_OK, position: POS_W'(idx_r), fill_count: FILL_W'(count_dec)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    mode_r  <= mode_nxt;
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Fill count exceeds capacity.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < IDX_W'(count_r) || full))
    else $error("Scan index beyond stored entries.");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_MOVE))
    else $error("Memory written outside append or move.");

  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("Remove did not decrement the fill count.");

endmodule

FILE: design/unordered_value_table_top.sv
// ----------------------------------------------------------------------------
// unordered_value_table_top
// Unordered table of 7-bit values with add, remove, find and count requests.
// ----------------------------------------------------------------------------
// Requests arrive on in_chan as one beat each, carrying a mode and a value.
// Every request produces exactly one result beat on out_chan with a status,
// the position that was added, found or removed, and the fill count after
// the request. Requests are handled one at a time.
// Add and count go straight to their result. Find and remove read the
// value memory one entry per cycle from index 0 through its single read
// port and stop at the first match or after the last stored entry; a
// remove that is not of the last entry then reads the last entry and
// writes it into the hole. A finished result moves from the sequencer's
// result register into the output register that drives out_chan.
// A result register sits at the output, so the block takes the next
// request while a result waits; when the receiver stalls with the register
// full, the sequencer holds its finished result and stops taking requests.
// Reset empties the table at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
module unordered_value_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  uvt_req_if.sink   in_chan,
  uvt_rsp_if.source out_chan
);
  import uvt_pkg::*;

  logic res_valid;
  logic res_ready;
  rsp_t res_data;

  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r, out_data_nxt;

  uvt_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_data_r.status;
  assign out_chan.position   = out_data_r.position;
  assign out_chan.fill_count = out_data_r.fill_count;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("Pending result beat was overwritten.");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> !res_valid)
    else $error("Sequencer offered a second result for one request.");

  a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("Request taken while another is in progress.");

endmodule
